[rtl/rprop_wu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rprop_wu_pkg;

	// Sequencer states of the update engine.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_FIN
	} state_t;

	// Item operation codes. Code three behaves as a read.
	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// Update modes.
	localparam logic MODE_GD    = 1'b0;
	localparam logic MODE_RPROP = 1'b1;

	// Stored gradient sign codes. Code three reads as zero sign.
	localparam logic [1:0] SG_ZERO = 2'd0;
	localparam logic [1:0] SG_POS  = 2'd1;
	localparam logic [1:0] SG_NEG  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_MODE     = 3'd0;
	localparam logic [2:0] CFG_LRATE    = 3'd1;
	localparam logic [2:0] CFG_MOMENTUM = 3'd2;
	localparam logic [2:0] CFG_ETA_PLUS = 3'd3;
	localparam logic [2:0] CFG_ETA_MIN  = 3'd4;
	localparam logic [2:0] CFG_STEP_MIN = 3'd5;
	localparam logic [2:0] CFG_STEP_MAX = 3'd6;
	localparam logic [2:0] CFG_MBATCH   = 3'd7;

	// Register reset values, all Q8.24 except the mode and the minibatch size.
	localparam logic [30:0] RST_LRATE    = 31'd18790482;
	localparam logic [30:0] RST_MOMENTUM = 31'd0;
	localparam logic [30:0] RST_ETA_PLUS = 31'd20132659;
	localparam logic [30:0] RST_ETA_MIN  = 31'd15938355;
	localparam logic [30:0] RST_STEP_MIN = 31'd17;
	localparam logic [30:0] RST_STEP_MAX = 31'd838860800;
	localparam logic [15:0] RST_MBATCH   = 16'd1;

	localparam logic [30:0] STEP_SAT = 31'h7FFFFFFF;

	// Write command from the sequencer to the entry store.
	typedef struct packed {
		logic        w_we;
		logic        ss_we;
		logic [31:0] weight;
		logic [30:0] step;
		logic [1:0]  sign;
	} store_wr_t;

endpackage

`default_nettype wire

[rtl/rprop_wu_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle from start to done.
module rprop_wu_div
	import rprop_wu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [16:0] rem_sh;
	logic [16:0] rem_sub;
	logic        fits;

	always_comb begin
		rem_sh  = {rem_q, quo_q[31]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], fits};
			rem_q <= fits ? rem_sub[15:0] : rem_sh[15:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[rtl/rprop_wu_store.sv]
`timescale 1ns / 1ps
`default_nettype none

// Entry store: a weight memory and a step/sign memory sharing one address,
// each with a registered read port.
module rprop_wu_store
	import rprop_wu_pkg::*;
#(
	parameter int ENTRIES = 256
) (
	input  wire logic                       clk,
	input  wire logic [$clog2(ENTRIES)-1:0] addr,
	input  wire logic                       rd_en,
	input  wire store_wr_t                  wr,
	output logic [31:0]                     rd_weight,
	output logic [30:0]                     rd_step,
	output logic [1:0]                      rd_sign
);

	logic [31:0] wmem [ENTRIES];
	logic [32:0] smem [ENTRIES];
	logic [31:0] w_rd_q;
	logic [32:0] s_rd_q;

	always_ff @(posedge clk) begin
		if (wr.w_we) begin
			wmem[addr] <= wr.weight;
		end
		if (rd_en) begin
			w_rd_q <= wmem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.ss_we) begin
			smem[addr] <= {wr.sign, wr.step};
		end
		if (rd_en) begin
			s_rd_q <= smem[addr];
		end
	end

	assign rd_weight = w_rd_q;
	assign rd_step   = s_rd_q[30:0];
	assign rd_sign   = s_rd_q[32:31];

endmodule

`default_nettype wire

[rtl/rprop_backprop_weight_updater_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Rprop / gradient-descent weight updater for one neuron. The block holds
// ENTRIES weights (the bias is one more entry) plus a per-entry step size and
// last gradient sign, all Q8.24, and handles one item at a time: update, load
// or read. Each item gives exactly one result carrying the entry's weight and
// step after the operation; an index at or beyond ENTRIES changes nothing and
// returns zeros. Items are handled by a read-modify-write of one entry through
// a single-port store with a registered read port and a single shared
// 33 x 33 multiplier. Load and read items go from the read state straight to
// the finish state, Rprop updates pass through two multiplier states, and
// gradient-descent updates through the bit-serial divide by the minibatch
// size followed by two multiplier passes. A finished result waits in the
// output register while the next item is already taken in. After reset the
// step/sign memory is swept to zero, during which items are stalled;
// configuration writes are accepted at any time but must only be made while the block is
// idle. Weights read before they were loaded are undefined.
module rprop_backprop_weight_updater_top
	import rprop_wu_pkg::*;
#(
	parameter int ENTRIES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Configuration write channel.
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	// Item channel.
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         op,
	input  wire logic [7:0]         entry_index,
	input  wire logic signed [31:0] operand_value,
	// Result channel.
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [31:0]      weight_out,
	output logic [30:0]             step_out
);

	localparam int AW = $clog2(ENTRIES);

	// Configuration registers.
	logic        mode_q;
	logic [30:0] lrate_q;
	logic [30:0] mom_q;
	logic [30:0] eta_p_q;
	logic [30:0] eta_m_q;
	logic [30:0] smin_q;
	logic [30:0] smax_q;
	logic [15:0] mb_q;

	// Sequencer and latched item.
	state_t       state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [1:0]   op_q;
	logic [7:0]   idx_q;
	logic [31:0]  opnd_q;
	logic         range_q;

	// Arithmetic registers.
	logic signed [65:0] prod_q;
	logic signed [41:0] a_q;
	logic signed [41:0] b_q;
	logic [30:0]        snew_q;

	// Output register.
	logic               res_vld_q;
	logic signed [31:0] wout_q;
	logic [30:0]        sout_q;

	// Store interface.
	logic [AW-1:0] addr;
	logic          rd_en;
	store_wr_t     wr;
	logic [31:0]   rd_w;
	logic [30:0]   rd_s;
	logic [1:0]    rd_sg;

	// Divider interface.
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quo;
	logic [31:0] g_mag;
	logic [15:0] mb_eff;

	logic        accept;
	logic        fin_go;
	logic        in_range;
	logic [AW+7:0] idx_ext_in;
	logic [AW+7:0] idx_ext_q;

	logic        g_pos, g_neg, grow, shrink;
	logic signed [32:0] q_sgn;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [30:0]        scaled;
	logic signed [43:0] gd_sum;
	logic signed [33:0] rp_sum;
	logic [31:0]        w_fin;
	logic [30:0]        s_fin;
	logic [1:0]         sg_new;

	// Q8.24 product rescale with truncation toward zero.
	function automatic logic signed [41:0] q_trunc(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + (p[65] ? 66'(24'hFFFFFF) : 66'd0);
		return t[65:24];
	endfunction

	function automatic logic [31:0] sat44(input logic signed [43:0] v);
		if (v[43:31] == {13{v[43]}}) begin
			return v[31:0];
		end
		return v[43] ? 32'h80000000 : 32'h7FFFFFFF;
	endfunction

	function automatic logic [31:0] sat34(input logic signed [33:0] v);
		if (v[33:31] == {3{v[33]}}) begin
			return v[31:0];
		end
		return v[33] ? 32'h80000000 : 32'h7FFFFFFF;
	endfunction

	// The configuration port never back-pressures.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_GD;
			lrate_q <= RST_LRATE;
			mom_q   <= RST_MOMENTUM;
			eta_p_q <= RST_ETA_PLUS;
			eta_m_q <= RST_ETA_MIN;
			smin_q  <= RST_STEP_MIN;
			smax_q  <= RST_STEP_MAX;
			mb_q    <= RST_MBATCH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:     mode_q  <= cfg_data[0];
				CFG_LRATE:    lrate_q <= cfg_data[30:0];
				CFG_MOMENTUM: mom_q   <= cfg_data[30:0];
				CFG_ETA_PLUS: eta_p_q <= cfg_data[30:0];
				CFG_ETA_MIN:  eta_m_q <= cfg_data[30:0];
				CFG_STEP_MIN: smin_q  <= cfg_data[30:0];
				CFG_STEP_MAX: smax_q  <= cfg_data[30:0];
				CFG_MBATCH:   mb_q    <= cfg_data[15:0];
				default:      mode_q  <= mode_q;
			endcase
		end
	end

	// Entry index mapped onto the store address; entries beyond the store
	// are flagged out of range and never write to it.
	assign idx_ext_in = {{AW{1'b0}}, entry_index};
	assign idx_ext_q  = {{AW{1'b0}}, idx_q};
	assign in_range   = (32'(entry_index) < 32'(ENTRIES));

	// Gradient sign against the stored sign. A reversal shrinks the step,
	// an agreeing sign grows it.
	always_comb begin
		g_pos  = !opnd_q[31] && (opnd_q != 32'd0);
		g_neg  = opnd_q[31];
		grow   = (rd_sg == SG_POS && g_pos) || (rd_sg == SG_NEG && g_neg);
		shrink = (rd_sg == SG_POS && g_neg) || (rd_sg == SG_NEG && g_pos);
	end

	// Divider operands: magnitude of the gradient over the minibatch size.
	assign g_mag  = opnd_q[31] ? (32'd0 - opnd_q) : opnd_q;
	assign mb_eff = (mb_q == 16'd0) ? 16'd1 : mb_q;
	assign q_sgn  = opnd_q[31] ? (33'sd0 - $signed({1'b0, div_quo}))
	                           : $signed({1'b0, div_quo});

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL1: begin
				if (mode_q == MODE_GD) begin
					mul_a = q_sgn;
					mul_b = $signed({2'b00, lrate_q});
				end else begin
					mul_a = $signed({2'b00, rd_s});
					mul_b = $signed({2'b00, (grow ? eta_p_q : eta_m_q)});
				end
			end
			ST_MUL2: begin
				mul_a = $signed({rd_w[31], rd_w});
				mul_b = $signed({2'b00, mom_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign scaled = (|prod_q[65:55]) ? STEP_SAT : prod_q[54:24];

	// Final weight and step of the item.
	always_comb begin
		gd_sum = $signed({{12{rd_w[31]}}, rd_w}) - $signed({{2{a_q[41]}}, a_q})
		       + $signed({{2{b_q[41]}}, b_q});
		if (g_pos) begin
			rp_sum = $signed({{2{rd_w[31]}}, rd_w}) - $signed({3'b000, snew_q});
		end else if (g_neg) begin
			rp_sum = $signed({{2{rd_w[31]}}, rd_w}) + $signed({3'b000, snew_q});
		end else begin
			rp_sum = $signed({{2{rd_w[31]}}, rd_w});
		end
		if (shrink) begin
			sg_new = SG_ZERO;
		end else if (g_pos) begin
			sg_new = SG_POS;
		end else if (g_neg) begin
			sg_new = SG_NEG;
		end else begin
			sg_new = SG_ZERO;
		end

		w_fin = rd_w;
		s_fin = rd_s;
		if (!range_q) begin
			w_fin = '0;
			s_fin = '0;
		end else begin
			case (op_q)
				OP_LOAD: w_fin = opnd_q;
				OP_UPDATE: begin
					if (mode_q == MODE_GD) begin
						w_fin = sat44(gd_sum);
					end else begin
						w_fin = shrink ? rd_w : sat34(rp_sum);
						s_fin = snew_q;
					end
				end
				default: w_fin = rd_w;
			endcase
		end
	end

	// Sequencer: next state, handshake and store control.
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		accept     = 1'b0;
		div_start  = 1'b0;
		fin_go     = 1'b0;
		rd_en      = 1'b0;
		addr       = idx_ext_q[AW-1:0];
		wr         = '0;
		case (state_q)
			ST_CLEAR: begin
				addr     = clr_q;
				wr.ss_we = 1'b1;
				if (clr_q == AW'(ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				addr       = idx_ext_in[AW-1:0];
				if (item_valid) begin
					accept  = 1'b1;
					rd_en   = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (range_q && op_q == OP_UPDATE) begin
					if (mode_q == MODE_GD) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						state_d = ST_MUL1;
					end
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = (mode_q == MODE_GD) ? ST_MUL3 : ST_FIN;
			ST_MUL3: state_d = ST_FIN;
			ST_FIN: begin
				if (!res_vld_q || !result_stall) begin
					fin_go    = 1'b1;
					wr.w_we   = range_q && (op_q == OP_LOAD || op_q == OP_UPDATE);
					wr.ss_we  = range_q && op_q == OP_UPDATE && mode_q == MODE_RPROP;
					wr.weight = w_fin;
					wr.step   = s_fin;
					wr.sign   = sg_new;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (fin_go) begin
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Item latch, arithmetic pipeline and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			idx_q   <= entry_index;
			opnd_q  <= operand_value;
			range_q <= in_range;
		end
		if (state_q == ST_MUL1 || state_q == ST_MUL2) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_MUL2) begin
			a_q <= q_trunc(prod_q);
			if (grow) begin
				snew_q <= (scaled > smax_q) ? smax_q : scaled;
			end else if (shrink) begin
				snew_q <= (scaled < smin_q) ? smin_q : scaled;
			end else begin
				snew_q <= rd_s;
			end
		end
		if (state_q == ST_MUL3) begin
			b_q <= q_trunc(prod_q);
		end
		if (fin_go) begin
			wout_q <= w_fin;
			sout_q <= s_fin;
		end
	end

	assign result_valid = res_vld_q;
	assign weight_out   = wout_q;
	assign step_out     = sout_q;

	rprop_wu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (g_mag),
		.divisor  (mb_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	rprop_wu_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk       (clk),
		.addr      (addr),
		.rd_en     (rd_en),
		.wr        (wr),
		.rd_weight (rd_w),
		.rd_step   (rd_s),
		.rd_sign   (rd_sg)
	);

endmodule

`default_nettype wire
